// ===== rtl/lvc_pkg.sv =====
// Package for the LRU vertex cache: sizes, types and the sequencer states.
package lvc_pkg;
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned CapW       = 5;
  localparam int unsigned WordW      = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REC,
    ST_DONE
  } state_e;

  function automatic cnt_t clamp_cap(logic [CapW-1:0] v);
    cnt_t c;
    if (v == '0) c = cnt_t'(1);
    else if (int'(v) > MaxEntries) c = cnt_t'(MaxEntries);
    else c = cnt_t'(v);
    return c;
  endfunction
endpackage

// ===== rtl/lvc_rec_ram.sv =====
// Record store: one write port, one registered read port.
module lvc_rec_ram
  import lvc_pkg::*;
(
  input  logic clk_i,
  input  logic we_i,
  input  idx_t waddr_i,
  input  rec_t wdata_i,
  input  idx_t raddr_i,
  output rec_t rdata_o
);
  rec_t mem [MaxEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/lru_vertex_cache.sv =====
// Top level of the LRU vertex cache: tag scan sequencer, recency ranks, counters.
// Fully associative cache of 16 three-word vertex records with LRU replacement.
// Pulse start with the index and fill record while busy is low. busy then stays
// high through the tag scan (one entry per cycle, each compared once its registered
// read returns), the rank update with the tag and record write, and the record
// read. The result shows on the result ports for exactly one cycle with done_o
// high, in the first cycle busy is low, and cannot be stalled. A new request is
// taken only once busy is low again. On a miss the fill record is returned
// directly. The totals count requests and hits since the last clear and wrap.
// Writing capacity through cfg_valid_i/cfg_ready_o clears the cache and both
// counters; cfg_ready_o is high only while no request is in flight and start is
// low. Tags and records live in synchronous memories; valid bits and ranks are
// flip-flops cleared at once.
module lru_vertex_cache
  import lvc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [WordW-1:0] vertex_index_i,
  input  logic [WordW-1:0] fill_x_i,
  input  logic [WordW-1:0] fill_y_i,
  input  logic [WordW-1:0] fill_z_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CapW-1:0]  cfg_data_i,
  output logic             done_o,
  output logic             hit_o,
  output logic [WordW-1:0] out_x_o,
  output logic [WordW-1:0] out_y_o,
  output logic [WordW-1:0] out_z_o,
  output logic [WordW-1:0] request_total_o,
  output logic [WordW-1:0] hit_total_o
);
  state_e state_q, state_d;
  cnt_t   cap_q, cnt_q;
  logic [MaxEntries-1:0] valid_q;
  idx_t   rank_q [MaxEntries];
  logic [WordW-1:0] req_q, hits_q, tag_q;
  rec_t   fill_q;
  logic [WordW-1:0] tag_mem [MaxEntries];
  logic [WordW-1:0] tag_rd_q;
  cnt_t   scan_q;       // address being read
  idx_t   rd_idx_q;     // index whose tag is in tag_rd_q
  logic   rd_ok_q;
  logic   hit_q;
  idx_t   slot_q;
  logic   found_q;
  idx_t   lru_q;        // entry with the oldest rank, gathered during scan
  idx_t   free_q;
  logic   free_ok_q;
  rec_t   rec_rd;
  logic   accept, cfg_we, wr_rec, last_cmp, match;

  assign accept = start && !busy;
  assign busy = (state_q != ST_IDLE);
  // a pending start wins over a config write in the same cycle
  assign cfg_ready_o = !busy && !start;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign match = rd_ok_q && valid_q[rd_idx_q] && tag_rd_q == tag_q;
  assign last_cmp = rd_ok_q && (int'(rd_idx_q) == MaxEntries - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: if (last_cmp) state_d = ST_REC;
      ST_REC:  state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Tag memory read one entry per cycle during the scan, until a match is found.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && !last_cmp && !(found_q || match))
      tag_rd_q <= tag_mem[scan_q[IdxW-1:0]];
    if (state_q == ST_REC && !hit_q) tag_mem[slot_q] <= tag_q;
  end

  // Final slot chosen at the end of the scan; the last entry's free check
  // is still in flight then, so it is looked at directly.
  idx_t sel_slot;
  logic sel_hit;
  always_comb begin
    sel_hit = found_q || match;
    if (found_q) sel_slot = slot_q;
    else if (match) sel_slot = rd_idx_q;
    else if (cnt_q >= cap_q) sel_slot = lru_q;
    else if (free_ok_q) sel_slot = free_q;
    else if (!valid_q[rd_idx_q]) sel_slot = rd_idx_q;
    else sel_slot = '0;
  end

  assign wr_rec = (state_q == ST_REC) && !hit_q;

  lvc_rec_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_rec),
    .waddr_i (slot_q),
    .wdata_i (fill_q),
    .raddr_i (slot_q),
    .rdata_o (rec_rd)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q  <= vertex_index_i;
      fill_q <= '{x: fill_x_i, y: fill_y_i, z: fill_z_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= cnt_t'(MaxEntries);
      cnt_q     <= '0;
      valid_q   <= '0;
      for (int i = 0; i < MaxEntries; i++) rank_q[i] <= '0;
      req_q     <= '0;
      hits_q    <= '0;
      scan_q    <= '0;
      rd_idx_q  <= '0;
      rd_ok_q   <= 1'b0;
      hit_q     <= 1'b0;
      slot_q    <= '0;
      found_q   <= 1'b0;
      lru_q     <= '0;
      free_q    <= '0;
      free_ok_q <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (cfg_we) begin
        cap_q   <= clamp_cap(cfg_data_i);
        cnt_q   <= '0;
        valid_q <= '0;
        for (int i = 0; i < MaxEntries; i++) rank_q[i] <= '0;
        req_q   <= '0;
        hits_q  <= '0;
      end
      unique case (state_q)
        ST_IDLE: if (accept) begin
          scan_q    <= '0;
          rd_ok_q   <= 1'b0;
          found_q   <= 1'b0;
          free_ok_q <= 1'b0;
          lru_q     <= '0;
          req_q     <= req_q + 1'b1;
        end
        ST_SCAN: begin
          // issue next read; track the compare of the previous one
          rd_idx_q <= scan_q[IdxW-1:0];
          rd_ok_q  <= 1'b1;
          scan_q   <= scan_q + 1'b1;
          if (match && !found_q) found_q <= 1'b1;
          if (rd_ok_q) begin
            if (!valid_q[rd_idx_q] && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= rd_idx_q;
            end
          end
          if (last_cmp) begin
            hit_q  <= sel_hit;
            slot_q <= sel_slot;
          end else if (match && !found_q) begin
            slot_q <= rd_idx_q;
          end
          // oldest rank: first valid entry with rank cnt-1
          if (!rd_ok_q && valid_q[scan_q[IdxW-1:0]] &&
              cnt_t'(rank_q[scan_q[IdxW-1:0]]) == cnt_q - 1'b1 && cnt_q != '0) begin
            lru_q <= scan_q[IdxW-1:0];
          end
        end
        ST_REC: begin
          // recency update, one parallel compare per entry
          for (int i = 0; i < MaxEntries; i++) begin
            if (valid_q[i] && idx_t'(i) != slot_q) begin
              if (hit_q) begin
                if (rank_q[i] < rank_q[slot_q]) rank_q[i] <= rank_q[i] + 1'b1;
              end else if (cnt_q >= cap_q) begin
                if (cnt_t'(rank_q[i]) < cnt_q - 1'b1) rank_q[i] <= rank_q[i] + 1'b1;
              end else begin
                if (cnt_t'(rank_q[i]) < cnt_q) rank_q[i] <= rank_q[i] + 1'b1;
              end
            end
          end
          rank_q[slot_q]  <= '0;
          valid_q[slot_q] <= 1'b1;
          if (hit_q) hits_q <= hits_q + 1'b1;
          else if (cnt_q < cap_q) cnt_q <= cnt_q + 1'b1;
        end
        ST_DONE: done_o <= 1'b1;
        default: ;
      endcase
      // LRU search uses a combinational pass over the ranks at scan start
      if (state_q == ST_IDLE && accept) begin
        for (int i = MaxEntries - 1; i >= 0; i--)
          if (valid_q[i] && cnt_q != '0 && cnt_t'(rank_q[i]) == cnt_q - 1'b1)
            lru_q <= idx_t'(i);
      end
    end
  end

  // On a miss the record read races the write of the same entry, so the
  // fill record is passed straight through.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      hit_o           <= hit_q;
      out_x_o         <= hit_q ? rec_rd.x : fill_q.x;
      out_y_o         <= hit_q ? rec_rd.y : fill_q.y;
      out_z_o         <= hit_q ? rec_rd.z : fill_q.z;
      request_total_o <= req_q;
      hit_total_o     <= hits_q;
    end
  end
endmodule

// ===== rtl/lvc_checker.sv =====
// Port-level checks of the LRU vertex cache, bound to the top level.
module lvc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic hit_o,
  input logic cfg_ready_o,
  input logic [31:0] request_total_o,
  input logic [31:0] hit_total_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("request not taken");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held longer than a cycle");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy) else $error("config open while busy");
  a_hit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && hit_o |-> hit_total_o != '0) else $error("hit not counted");
endmodule

bind lru_vertex_cache lvc_checker u_lvc_checker (.*);
